[rtl/qaie_pkg.sv]
// qaie_pkg: types and constants shared by the q-axis inductance estimator
// no dependencies; imported by the controller, datapath and divider
package qaie_pkg;

    // register indexes on the configuration channel
    localparam logic [2:0] CFG_RES     = 3'd0;
    localparam logic [2:0] CFG_RATE    = 3'd1;
    localparam logic [2:0] CFG_MIN_VQ  = 3'd2;
    localparam logic [2:0] CFG_MIN_SL  = 3'd3;
    localparam logic [2:0] CFG_MAX_ID  = 3'd4;
    localparam logic [2:0] CFG_MAX_WE  = 3'd5;
    localparam logic [2:0] CFG_MAX_IQ  = 3'd6;

    // register reset values
    localparam logic [15:0] RST_RES    = 16'd0;
    localparam logic [19:0] RST_RATE   = 20'd10000;
    localparam logic [14:0] RST_MIN_VQ = 15'd128;
    localparam logic [31:0] RST_MIN_SL = 32'd1;
    localparam logic [14:0] RST_MAX_ID = 15'd205;
    localparam logic [14:0] RST_MAX_WE = 15'd3;
    localparam logic [14:0] RST_MAX_IQ = 15'd3072;

    // filter gain 0.1 in q16 and rounding term
    localparam logic signed [14:0] SLOPE_GAIN = 15'sd6554;
    localparam logic signed [63:0] Q16_ROUND  = 64'sd32768;

    // valid estimate window, units 2^-24 H (0.001 H and 0.2 H)
    localparam logic signed [46:0] LQ_LO = 47'sd16777;
    localparam logic signed [46:0] LQ_HI = 47'sd3355443;

    // shared divider geometry
    localparam int DIVD_W = 46;
    localparam int DIVS_W = 48;
    localparam int ITER_W = 6;
    localparam logic [ITER_W-1:0] DIV_LONG  = 6'd46;
    localparam logic [ITER_W-1:0] DIV_SHORT = 6'd23;

    typedef enum logic [3:0] {
        S_IDLE, S_SLOPE, S_MUL, S_FILT, S_GATE, S_DIV1,
        S_CHK, S_MSTART, S_DIV2, S_MEAN, S_DONE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic do_slope;
        logic do_mul;
        logic do_filt;
        logic div1_start;
        logic do_chk;
        logic div2_start;
        logic do_mean;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic gate;
        logic div_done;
        logic est_valid;
        logic first;
        logic out_free;
    } t_dp_sts;

endpackage

[rtl/qaie_if.sv]
// qaie channel interfaces: sample input, result output, configuration write
// no dependencies
interface qaie_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] q_voltage;
    logic signed [15:0] q_current;
    logic signed [15:0] d_current;
    logic signed [15:0] elec_speed;
    logic               enable;
    modport source (output valid, q_voltage, q_current, d_current, elec_speed, enable,
                    input ready);
    modport sink   (input valid, q_voltage, q_current, d_current, elec_speed, enable,
                    output ready);
endinterface

interface qaie_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] filtered_slope;
    logic signed [31:0] raw_inductance;
    logic [21:0]        mean_inductance;
    logic               estimate_valid;
    modport source (output valid, filtered_slope, raw_inductance, mean_inductance,
                    estimate_valid, input ready);
    modport sink   (input valid, filtered_slope, raw_inductance, mean_inductance,
                    estimate_valid, output ready);
endinterface

interface qaie_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/qaie_div.sv]
// qaie_div: restoring unsigned divider, one quotient bit per cycle
// depends on qaie_pkg; dividend is pre-aligned so the top bits come out first
module qaie_div
    import qaie_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ITER_W-1:0] i_iters,
    input  logic [DIVD_W-1:0] i_dividend,
    input  logic [DIVS_W-1:0] i_divisor,
    output logic [DIVD_W-1:0] o_quotient,
    output logic              o_done
);

    logic [DIVS_W-1:0] r_rem, n_rem;
    logic [DIVD_W-1:0] r_quo, n_quo;
    logic [DIVS_W-1:0] r_div;
    logic [ITER_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;
    logic [DIVS_W:0]   shifted;
    logic [DIVS_W:0]   trial;

    // one trial subtract per cycle
    always_comb begin
        shifted = {r_rem, r_quo[DIVD_W-1]};
        trial   = shifted - {1'b0, r_div};
        if (!trial[DIVS_W]) begin
            n_rem = trial[DIVS_W-1:0];
            n_quo = {r_quo[DIVD_W-2:0], 1'b1};
        end else begin
            n_rem = shifted[DIVS_W-1:0];
            n_quo = {r_quo[DIVD_W-2:0], 1'b0};
        end
    end

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == ITER_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_iters;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // operand registers
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

[rtl/qaie_dp.sv]
// qaie_dp: datapath with configuration registers, slope filter, gate,
// estimate and running mean; depends on qaie_pkg, qaie_if and qaie_div
module qaie_dp
    import qaie_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    qaie_in_if.sink     i_in,
    qaie_cfg_if.sink    i_cfg,
    qaie_out_if.source  o_out,
    input  t_dp_cmd i_cmd,
    output t_dp_sts o_sts
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    // configuration
    logic [15:0] r_res;
    logic [19:0] r_rate;
    logic [14:0] r_min_vq;
    logic [31:0] r_min_sl;
    logic [14:0] r_max_id;
    logic [14:0] r_max_we;
    logic [14:0] r_max_iq;

    // sample and state
    logic signed [15:0] r_vq, r_iq, r_id, r_we;
    logic               r_en;
    logic signed [15:0] r_last;
    logic signed [37:0] r_slope;
    logic signed [32:0] r_riq;
    logic signed [63:0] r_prod;
    logic signed [47:0] r_filt;
    logic signed [33:0] r_num;
    logic               r_sign;
    logic signed [31:0] r_raw;
    logic               r_est;
    logic [21:0]        r_q22;
    logic [21:0]        r_mean;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic               r_ovalid;
    logic signed [47:0] r_oslope;
    logic signed [31:0] r_oraw;
    logic [21:0]        r_omean;
    logic               r_oest;

    // combinational terms
    logic signed [16:0] diff;
    logic signed [20:0] rate_s;
    logic signed [37:0] n_slope;
    logic signed [16:0] res_s;
    logic signed [32:0] n_riq;
    logic signed [48:0] delta;
    logic signed [63:0] n_prod;
    logic signed [63:0] step64;
    logic signed [49:0] sum50;
    logic signed [47:0] n_filt;
    logic signed [33:0] n_num;
    logic signed [16:0] vq_x, id_x, we_x, iq_x;
    logic [16:0]        vq_m, id_m, we_m, iq_m;
    logic signed [48:0] f_x;
    logic [47:0]        f_m;
    logic [33:0]        num_m;
    logic signed [22:0] md;
    logic [22:0]        md_m;
    logic [DIVD_W-1:0]  quo;
    logic               div_done;
    logic [DIVD_W-1:0]  dvd;
    logic [DIVS_W-1:0]  dvs;
    logic [ITER_W-1:0]  iters;
    logic signed [46:0] qs;
    logic signed [31:0] q_sat;
    logic               q_ok;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic signed [22:0] mq;
    logic [22:0]        n_mean;

    // configuration writes, always ready
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res    <= RST_RES;
            r_rate   <= RST_RATE;
            r_min_vq <= RST_MIN_VQ;
            r_min_sl <= RST_MIN_SL;
            r_max_id <= RST_MAX_ID;
            r_max_we <= RST_MAX_WE;
            r_max_iq <= RST_MAX_IQ;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_RES:    r_res    <= i_cfg.data[15:0];
                CFG_RATE:   r_rate   <= i_cfg.data[19:0];
                CFG_MIN_VQ: r_min_vq <= i_cfg.data[14:0];
                CFG_MIN_SL: r_min_sl <= i_cfg.data;
                CFG_MAX_ID: r_max_id <= i_cfg.data[14:0];
                CFG_MAX_WE: r_max_we <= i_cfg.data[14:0];
                CFG_MAX_IQ: r_max_iq <= i_cfg.data[14:0];
                default: ;
            endcase
        end
    end

    // slope, filter and numerator arithmetic
    always_comb begin
        diff    = 17'(r_iq) - 17'(r_last);
        rate_s  = $signed({1'b0, r_rate});
        n_slope = 38'(diff * rate_s);
        res_s   = $signed({1'b0, r_res});
        n_riq   = 33'(res_s * r_iq);
        delta   = 49'(r_slope) - 49'(r_filt);
        n_prod  = 64'(delta * SLOPE_GAIN);
        step64  = (r_prod + Q16_ROUND) >>> 16;
        sum50   = 50'(r_filt) + step64[49:0];
        if (sum50 > 50'sh0_7FFF_FFFF_FFFF) begin
            n_filt = 48'sh7FFF_FFFF_FFFF;
        end else if (sum50 < -50'sh0_8000_0000_0000) begin
            n_filt = 48'sh8000_0000_0000;
        end else begin
            n_filt = sum50[47:0];
        end
        n_num = 34'($signed({r_vq, 15'd0})) - 34'(r_riq);
    end

    // magnitudes for the operating point gate
    always_comb begin
        vq_x  = 17'(r_vq);
        id_x  = 17'(r_id);
        we_x  = 17'(r_we);
        iq_x  = 17'(r_iq);
        vq_m  = vq_x[16] ? 17'(-vq_x) : 17'(vq_x);
        id_m  = id_x[16] ? 17'(-id_x) : 17'(id_x);
        we_m  = we_x[16] ? 17'(-we_x) : 17'(we_x);
        iq_m  = iq_x[16] ? 17'(-iq_x) : 17'(iq_x);
        f_x   = 49'(r_filt);
        f_m   = f_x[48] ? 48'(-f_x) : 48'(f_x);
        num_m = r_num[33] ? 34'(-r_num) : 34'(r_num);
    end

    assign o_sts.gate = r_en
                     && (vq_m > 17'(r_min_vq))
                     && (f_m > 48'(r_min_sl))
                     && (id_m < 17'(r_max_id))
                     && (we_m < 17'(r_max_we))
                     && (iq_m < 17'(r_max_iq));

    // mean update operands
    always_comb begin
        md   = $signed({1'b0, r_q22}) - $signed({1'b0, r_mean});
        md_m = md[22] ? 23'(-md) : 23'(md);
    end

    // shared divider operand select
    always_comb begin
        if (i_cmd.div2_start) begin
            dvd   = {md_m, 23'd0};
            dvs   = DIVS_W'(r_cnt);
            iters = DIV_SHORT;
        end else begin
            dvd   = {num_m, 12'd0};
            dvs   = f_m;
            iters = DIV_LONG;
        end
    end

    qaie_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div1_start | i_cmd.div2_start),
        .i_iters    (iters),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_quotient (quo),
        .o_done     (div_done)
    );

    // estimate checks and counter
    always_comb begin
        qs = r_sign ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
        if (qs > 47'sd2147483647) begin
            q_sat = 32'sh7FFF_FFFF;
        end else if (qs < -47'sd2147483648) begin
            q_sat = 32'sh8000_0000;
        end else begin
            q_sat = qs[31:0];
        end
        q_ok   = (qs > LQ_LO) && (qs < LQ_HI);
        n_cnt  = (r_cnt < CountMax) ? r_cnt + 1'b1 : r_cnt;
        mq     = r_sign ? -$signed(quo[22:0]) : $signed(quo[22:0]);
        n_mean = 23'({1'b0, r_mean}) + 23'(mq);
    end

    assign o_sts.div_done  = div_done;
    assign o_sts.est_valid = q_ok;
    assign o_sts.first     = (n_cnt == COUNT_WIDTH'(1));
    assign o_sts.out_free  = !r_ovalid || o_out.ready;

    // control state of the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last   <= '0;
            r_filt   <= '0;
            r_mean   <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
            r_raw    <= '0;
            r_est    <= 1'b0;
        end else begin
            if (i_cmd.load_in) begin
                r_raw <= '0;
                r_est <= 1'b0;
            end
            if (i_cmd.do_slope) begin
                r_last <= r_iq;
            end
            if (i_cmd.do_filt) begin
                r_filt <= n_filt;
            end
            if (i_cmd.do_chk) begin
                r_raw <= q_sat;
                r_est <= q_ok;
                if (q_ok) begin
                    r_cnt <= n_cnt;
                    if (n_cnt == COUNT_WIDTH'(1)) begin
                        r_mean <= qs[21:0];
                    end
                end
            end
            if (i_cmd.do_mean) begin
                r_mean <= n_mean[21:0];
            end
            if (i_cmd.load_out) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_vq <= i_in.q_voltage;
            r_iq <= i_in.q_current;
            r_id <= i_in.d_current;
            r_we <= i_in.elec_speed;
            r_en <= i_in.enable;
        end
        if (i_cmd.do_slope) begin
            r_slope <= n_slope;
            r_riq   <= n_riq;
        end
        if (i_cmd.do_mul) begin
            r_prod <= n_prod;
        end
        if (i_cmd.do_filt) begin
            r_num <= n_num;
        end
        if (i_cmd.div1_start) begin
            r_sign <= r_num[33] ^ r_filt[47];
        end
        if (i_cmd.div2_start) begin
            r_sign <= md[22];
        end
        if (i_cmd.do_chk) begin
            r_q22 <= qs[21:0];
        end
        if (i_cmd.load_out) begin
            r_oslope <= r_filt;
            r_oraw   <= r_raw;
            r_omean  <= r_mean;
            r_oest   <= r_est;
        end
    end

    assign o_out.valid           = r_ovalid;
    assign o_out.filtered_slope  = r_oslope;
    assign o_out.raw_inductance  = r_oraw;
    assign o_out.mean_inductance = r_omean;
    assign o_out.estimate_valid  = r_oest;

    // a flagged estimate always lies inside the window
    a_est_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_est |-> ((48'(r_raw) > 48'(LQ_LO)) && (48'(r_raw) < 48'(LQ_HI))))
        else $error("valid estimate outside window");

    // valid count only steps up by one
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cnt) |-> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("valid count jumped");

    // output register reloaded only when free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_ovalid || o_out.ready))
        else $error("result overwritten");

endmodule

[rtl/qaie_ctrl.sv]
// qaie_ctrl: sequencer for one sample through filter, divide and mean
// depends on qaie_pkg
module qaie_ctrl
    import qaie_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_SLOPE;
                end
            end
            S_SLOPE: begin
                o_cmd.do_slope = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                o_cmd.do_mul = 1'b1;
                n_state = S_FILT;
            end
            S_FILT: begin
                o_cmd.do_filt = 1'b1;
                n_state = S_GATE;
            end
            S_GATE: begin
                if (i_sts.gate) begin
                    o_cmd.div1_start = 1'b1;
                    n_state = S_DIV1;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV1: begin
                if (i_sts.div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.do_chk = 1'b1;
                if (i_sts.est_valid && !i_sts.first) begin
                    n_state = S_MSTART;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MSTART: begin
                o_cmd.div2_start = 1'b1;
                n_state = S_DIV2;
            end
            S_DIV2: begin
                if (i_sts.div_done) begin
                    n_state = S_MEAN;
                end
            end
            S_MEAN: begin
                o_cmd.do_mean = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // a transfer in starts the slope step
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_SLOPE))
        else $error("accepted sample not started");

    // first divider wait holds until done
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV1 && !i_sts.div_done) |=> (r_state == S_DIV1))
        else $error("left divide early");

    // result handed over returns to idle
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_sts.out_free) |=> (r_state == S_IDLE))
        else $error("stuck after result");

endmodule

[rtl/q_axis_inductance_estimator.sv]
// q_axis_inductance_estimator: top level joining controller and datapath
// depends on qaie_pkg, qaie_if, qaie_ctrl, qaie_dp (and qaie_div)
//
//  channel  dir  contents
//  i_in     in   q_voltage, q_current, d_current, elec_speed, enable
//  o_out    out  filtered_slope, raw_inductance, mean_inductance, estimate_valid
//  i_cfg    in   index (0..6), data; always ready
//
// a sample not estimated skips the divider; an estimate divides once, and
// a mean update divides again: the shared divider does 46 then 23 bits,
// one bit a cycle. a new sample is taken once the previous one is in the
// output register; a stalled output holds the result and blocks only the
// next hand-off. synchronous active-low reset clears state, not payloads.
module q_axis_inductance_estimator
    import qaie_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qaie_in_if.sink    i_in,
    qaie_cfg_if.sink   i_cfg,
    qaie_out_if.source o_out
);

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;

    assign i_in.ready = in_ready;

    qaie_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    qaie_dp #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .o_out   (o_out),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule
